// ===== rtl/rewp_pkg.sv =====
// Shared types and constants for the rolling extreme with position block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package rewp_pkg;

   localparam int SAMPLE_BITS = 32;
   localparam int WIN_W       = 7;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_IDX_W   = 2;

   // Register indexes, decoded from paddr word bits
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_LEN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_VALID  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FIND_MIN   = 2'd2;

   localparam logic [WIN_W-1:0] WINDOW_LEN_RESET = 7'd1;
   localparam logic [WIN_W-1:0] MIN_VALID_RESET  = 7'd1;

   // Order-preserving unsigned key: sample with the sign bit flipped
   typedef logic [SAMPLE_BITS-1:0] key_type;
   localparam key_type KEY_SIGN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam key_type KEY_LOW  = '0;
   localparam key_type KEY_HIGH = '1;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          sample_present;
      logic                          series_start;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] extreme_value;
      logic [WIN_W-1:0]              extreme_position;
      logic                          result_valid;
   } rsp_type;

   typedef struct packed {
      key_type key;
      logic    present;
   } entry_type;

   // Operands of the shared compare unit
   typedef struct packed {
      key_type a;
      key_type b;
      logic    ties;
      logic    find_min;
   } cmp_req_type;

endpackage

`default_nettype wire

// ===== rtl/rewp_cmp.sv =====
// Shared compare unit: does key a beat key b under the current mode.
// Depends on rewp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rewp_cmp (
   input  rewp_pkg::cmp_req_type cmp_req,
   output logic                  beats
);
   import rewp_pkg::*;

   always_comb begin
      if (cmp_req.find_min) begin
         beats = cmp_req.ties ? (cmp_req.a <= cmp_req.b) : (cmp_req.a < cmp_req.b);
      end else begin
         beats = cmp_req.ties ? (cmp_req.a >= cmp_req.b) : (cmp_req.a > cmp_req.b);
      end
   end

endmodule

`default_nettype wire

// ===== rtl/rolling_extreme_with_position_core.sv =====
// Top level of the rolling extreme with position block: CSRs, window memory,
// scan sequencer and result register. Depends on rewp_pkg and rewp_cmp.
//
//   channel   direction  signals                              handshake
//   req       in         req_valid, req_ready, req_data       valid/ready
//   rsp       out        rsp_valid, rsp_ready, rsp_data       valid/ready
//   csr       in/out     csr_psel .. csr_pready (APB style)   pready tied high
//
// While a series fills, each accepted request goes through ST_FIN back to ST_IDLE.
// With a full window every request rescans all W entries of the window through the
// single memory read port (W = effective window length).
// Synchronous active-high reset; the window memory is not cleared.
// A result waiting in the output register does not block the next request;
// only a second finished result stalls until rsp_ready.
`timescale 1ns / 1ps
`default_nettype none

module rolling_extreme_with_position_core #(
   parameter int MAX_WINDOW = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  rewp_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output rewp_pkg::rsp_type                   rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [rewp_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [rewp_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [rewp_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import rewp_pkg::*;

   localparam int ADDR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
   localparam int EXT_W  = (CNT_W > WIN_W) ? CNT_W : WIN_W;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FIN} state_type;

   // ---------------- configuration registers ----------------
   logic [WIN_W-1:0] window_len_ff;
   logic [WIN_W-1:0] min_valid_ff;
   logic             find_min_ff;
   logic             csr_write;
   logic [CSR_IDX_W-1:0] csr_idx;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff <= WINDOW_LEN_RESET;
         min_valid_ff  <= MIN_VALID_RESET;
         find_min_ff   <= 1'b0;
      end else if (csr_write) begin
         case (csr_idx)
            REG_WINDOW_LEN: window_len_ff <= csr_pwdata[WIN_W-1:0];
            REG_MIN_VALID:  min_valid_ff  <= csr_pwdata[WIN_W-1:0];
            REG_FIND_MIN:   find_min_ff   <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_WINDOW_LEN: csr_prdata = {{(CSR_DATA_W-WIN_W){1'b0}}, window_len_ff};
         REG_MIN_VALID:  csr_prdata = {{(CSR_DATA_W-WIN_W){1'b0}}, min_valid_ff};
         REG_FIND_MIN:   csr_prdata = {{(CSR_DATA_W-1){1'b0}}, find_min_ff};
         default:        csr_prdata = '0;
      endcase
   end

   // ---------------- effective window ----------------
   logic [EXT_W-1:0] wl_ext;
   logic [EXT_W-1:0] mv_ext;
   logic [EXT_W-1:0] w_ext;
   logic [CNT_W-1:0] w_eff;
   key_type          end_key;

   assign wl_ext  = EXT_W'(window_len_ff);
   assign mv_ext  = EXT_W'(min_valid_ff);
   assign w_ext   = (wl_ext == '0) ? EXT_W'(1) :
                    ((wl_ext > EXT_W'(MAX_WINDOW)) ? EXT_W'(MAX_WINDOW) : wl_ext);
   assign w_eff   = w_ext[CNT_W-1:0];
   assign end_key = find_min_ff ? KEY_HIGH : KEY_LOW;

   // ---------------- sequencer state ----------------
   state_type        state_ff, state_in;
   logic [ADDR_W-1:0] wp_ff, wp_in;
   logic [CNT_W-1:0] seen_ff, seen_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   key_type          cur_ff, cur_in;
   logic [CNT_W-1:0] age_ff, age_in;
   logic             stale_ff, stale_in;
   logic             search_ff, search_in;
   logic             full_ff, full_in;
   logic [ADDR_W-1:0] scan_addr_ff, scan_addr_in;
   logic [ADDR_W-1:0] scan_k_ff, scan_k_in;
   logic             issue_ff, issue_in;
   logic             issue_first_ff, issue_first_in;
   logic             rd_vld_ff, rd_vld_in;
   logic             rd_first_ff, rd_first_in;
   logic [ADDR_W-1:0] rd_k_ff, rd_k_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   // ---------------- window memory ----------------
   entry_type        store_ff [MAX_WINDOW];
   entry_type        rd_data_ff;
   logic             mem_we;
   entry_type        mem_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_ff[wp_ff] <= mem_wdata;
      end
      rd_data_ff <= store_ff[scan_addr_ff];
   end

   // ---------------- request-side values ----------------
   key_type          in_key;
   logic             in_start;
   logic             stale_s;
   key_type          cur_s;
   logic [CNT_W-1:0] age_s;
   logic [CNT_W-1:0] seen_s;
   logic [CNT_W-1:0] seen_n;
   logic [CNT_W-1:0] age_n;
   logic [ADDR_W-1:0] wp_n;
   logic [ADDR_W:0]  start_sum;
   logic [ADDR_W:0]  start_addr;
   logic             fill;
   logic             search;
   logic             accept;

   assign accept   = req_valid & req_ready;
   assign in_key   = key_type'(req_data.sample) ^ KEY_SIGN;
   assign in_start = req_data.series_start;
   assign stale_s  = in_start | stale_ff;
   assign cur_s    = in_start ? end_key : cur_ff;
   assign age_s    = in_start ? '0 : age_ff;
   assign seen_s   = in_start ? '0 : seen_ff;
   assign seen_n   = (seen_s < CNT_W'(MAX_WINDOW)) ? seen_s + CNT_W'(1) : seen_s;
   assign age_n    = (!stale_s && (age_s < CNT_W'(MAX_WINDOW))) ? age_s + CNT_W'(1) : age_s;
   assign wp_n     = (wp_ff == ADDR_W'(MAX_WINDOW - 1)) ? '0 : wp_ff + ADDR_W'(1);
   assign fill     = seen_n < w_eff;
   assign search   = !fill && (stale_s || (age_n >= w_eff));
   // oldest window slot: write pointer after this request minus W, modulo depth
   assign start_sum  = {1'b0, wp_n} + (ADDR_W+1)'(MAX_WINDOW) - (ADDR_W+1)'(w_eff);
   assign start_addr = (start_sum >= (ADDR_W+1)'(MAX_WINDOW)) ?
                       start_sum - (ADDR_W+1)'(MAX_WINDOW) : start_sum;

   // ---------------- shared compare unit ----------------
   cmp_req_type cmp_req;
   logic        cmp_beats;

   always_comb begin
      cmp_req.find_min = find_min_ff;
      if (state_ff == ST_SCAN) begin
         cmp_req.a    = rd_data_ff.key;
         cmp_req.b    = cur_ff;
         cmp_req.ties = 1'b1;
      end else begin
         cmp_req.a    = in_key;
         cmp_req.b    = stale_s ? end_key : cur_s;
         cmp_req.ties = !fill;
      end
   end

   rewp_cmp u_cmp (
      .cmp_req (cmp_req),
      .beats   (cmp_beats)
   );

   // ---------------- result check ----------------
   logic [EXT_W-1:0] cnt_ext;
   logic             result_ok;
   logic [CNT_W-1:0] pos_cnt;
   logic [EXT_W-1:0] pos_ext;

   assign cnt_ext   = EXT_W'(cnt_ff);
   assign result_ok = full_ff && (w_ext >= mv_ext) && (cnt_ext >= mv_ext);
   assign pos_cnt   = w_eff - age_ff;
   assign pos_ext   = EXT_W'(pos_cnt);

   // ---------------- next state ----------------
   always_comb begin
      state_in       = state_ff;
      wp_in          = wp_ff;
      seen_in        = seen_ff;
      cnt_in         = cnt_ff;
      cur_in         = cur_ff;
      age_in         = age_ff;
      stale_in       = stale_ff;
      search_in      = search_ff;
      full_in        = full_ff;
      scan_addr_in   = scan_addr_ff;
      scan_k_in      = scan_k_ff;
      issue_in       = issue_ff;
      issue_first_in = issue_first_ff;
      rd_vld_in      = 1'b0;
      rd_first_in    = 1'b0;
      rd_k_in        = rd_k_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;
      mem_we         = 1'b0;
      mem_wdata.key     = in_key;
      mem_wdata.present = req_data.sample_present;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mem_we         = 1'b1;
               wp_in          = wp_n;
               seen_in        = seen_n;
               cnt_in         = '0;
               search_in      = search;
               full_in        = !fill;
               scan_addr_in   = start_addr[ADDR_W-1:0];
               scan_k_in      = ADDR_W'(w_eff - CNT_W'(1));
               issue_in       = !fill;
               issue_first_in = 1'b1;
               if (req_data.sample_present && cmp_beats && !search) begin
                  cur_in   = in_key;
                  age_in   = '0;
                  stale_in = 1'b0;
               end else begin
                  cur_in   = cur_s;
                  age_in   = age_n;
                  stale_in = stale_s;
               end
               state_in = fill ? ST_FIN : ST_SCAN;
            end
         end

         ST_SCAN: begin
            // issue one read a cycle, oldest slot first
            if (issue_ff) begin
               rd_vld_in      = 1'b1;
               rd_first_in    = issue_first_ff;
               rd_k_in        = scan_k_ff;
               issue_first_in = 1'b0;
               scan_addr_in   = (scan_addr_ff == ADDR_W'(MAX_WINDOW - 1)) ?
                                '0 : scan_addr_ff + ADDR_W'(1);
               if (scan_k_ff == '0) begin
                  issue_in = 1'b0;
               end else begin
                  scan_k_in = scan_k_ff - ADDR_W'(1);
               end
            end
            // evaluate the entry read last cycle
            if (rd_vld_ff) begin
               if (rd_data_ff.present) begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
               if (search_ff) begin
                  if (rd_first_ff) begin
                     cur_in   = rd_data_ff.present ? rd_data_ff.key : end_key;
                     age_in   = CNT_W'(rd_k_ff);
                     stale_in = 1'b0;
                  end else if (rd_data_ff.present && cmp_beats) begin
                     cur_in = rd_data_ff.key;
                     age_in = CNT_W'(rd_k_ff);
                  end
               end
               if (rd_k_ff == '0) begin
                  state_in = ST_FIN;
               end
            end
         end

         ST_FIN: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               if (result_ok) begin
                  rsp_data_in.extreme_value    = cur_ff ^ KEY_SIGN;
                  rsp_data_in.extreme_position = pos_ext[WIN_W-1:0];
                  rsp_data_in.result_valid     = 1'b1;
               end else begin
                  rsp_data_in = '0;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         wp_ff          <= '0;
         seen_ff        <= '0;
         cnt_ff         <= '0;
         cur_ff         <= KEY_LOW;
         age_ff         <= '0;
         stale_ff       <= 1'b1;
         search_ff      <= 1'b0;
         full_ff        <= 1'b0;
         issue_ff       <= 1'b0;
         issue_first_ff <= 1'b0;
         rd_vld_ff      <= 1'b0;
         rd_first_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         wp_ff          <= wp_in;
         seen_ff        <= seen_in;
         cnt_ff         <= cnt_in;
         cur_ff         <= cur_in;
         age_ff         <= age_in;
         stale_ff       <= stale_in;
         search_ff      <= search_in;
         full_ff        <= full_in;
         issue_ff       <= issue_in;
         issue_first_ff <= issue_first_in;
         rd_vld_ff      <= rd_vld_in;
         rd_first_ff    <= rd_first_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      scan_addr_ff <= scan_addr_in;
      scan_k_ff    <= scan_k_in;
      rd_k_ff      <= rd_k_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/rewp_checker.sv =====
// Port-level checks for rolling_extreme_with_position_core, attached by bind.
// Depends on rewp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rewp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input rewp_pkg::rsp_type rsp_data
);
   import rewp_pkg::*;

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // one request at a time: ready drops right after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready held after accepting a request");

   // an invalid result carries zero value and position
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.result_valid |->
         rsp_data.extreme_value == '0 && rsp_data.extreme_position == '0)
      else $error("invalid result with nonzero payload");

   // a valid result has a position of at least one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_valid |-> rsp_data.extreme_position != '0)
      else $error("valid result with zero position");

endmodule

bind rolling_extreme_with_position_core rewp_checker u_rewp_checker (.*);

`default_nettype wire
